>>> design/tsts_pkg.sv
// Shared constants and types for the TDMA slot timer sync pipeline.
package tsts_pkg;

  localparam int PERIOD_BITS = 16;
  localparam int TU_SHIFT    = 10;
  localparam int MOD_W       = PERIOD_BITS + TU_SHIFT;
  localparam int SLOT_W      = PERIOD_BITS + 1;
  localparam int TBTT_W      = 32 + TU_SHIFT;
  localparam int IVAL_W      = 16;
  localparam int PULL_W      = 11;
  localparam int SPAN_W      = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [19:0] SLOT_LENGTH_RST = 20'd10000;
  localparam logic [15:0] GUARD_TIME_RST  = 16'd0;
  localparam logic [3:0]  SLOT_COUNT_RST  = 4'd2;
  localparam logic [15:0] DBA_PREP_RST    = 16'd0;
  localparam logic [15:0] SWBA_PREP_RST   = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_LENGTH = 3'd0,
    REG_GUARD_TIME  = 3'd1,
    REG_SLOT_COUNT  = 3'd2,
    REG_DBA_PREP    = 3'd3,
    REG_SWBA_PREP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] slot_length_us;
    logic [15:0] guard_time_us;
    logic [3:0]  slot_count;
    logic [15:0] dba_prep_time;
    logic [15:0] swba_prep_time;
  } cfg_t;

  // front end -> phase error
  typedef struct packed {
    logic              valid;
    logic [MOD_W-1:0]  nextslot;
    logic [IVAL_W-1:0] ival;
    logic [TBTT_W-1:0] tbtt;
  } front_t;

  // phase error -> timer update
  typedef struct packed {
    logic                   valid;
    logic [PERIOD_BITS-1:0] slot;
    logic                   inc;
    logic [PULL_W-1:0]      pull;
    logic [IVAL_W-1:0]      ival;
    logic [31:0]            tbtt_tu;
  } phase_t;

endpackage

>>> design/tsts_cfg_regs.sv
// Configuration register file with write decode and reset values.
module tsts_cfg_regs import tsts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slot_length_us <= SLOT_LENGTH_RST;
      regs.guard_time_us  <= GUARD_TIME_RST;
      regs.slot_count     <= SLOT_COUNT_RST;
      regs.dba_prep_time  <= DBA_PREP_RST;
      regs.swba_prep_time <= SWBA_PREP_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOT_LENGTH: regs.slot_length_us <= cfg_data[19:0];
        REG_GUARD_TIME:  regs.guard_time_us  <= cfg_data[15:0];
        REG_SLOT_COUNT:  regs.slot_count     <= cfg_data[3:0];
        REG_DBA_PREP:    regs.dba_prep_time  <= cfg_data[15:0];
        REG_SWBA_PREP:   regs.swba_prep_time <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> design/tsts_front.sv
// Stages 1-3: beacon interval from config and next slot time.
module tsts_front import tsts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [63:0] rx_timestamp_us,
  input  logic [15:0] frame_airtime_us,
  input  logic [63:0] next_tbtt_us,
  output front_t      front
);

  // stage 1
  logic              v1;
  logic [SPAN_W-1:0] span1;
  logic [31:0]       rel1;
  logic [TBTT_W-1:0] tbtt1;
  // stage 2
  logic              v2;
  logic [IVAL_W-1:0] ival2;
  logic [31:0]       rel2;
  logic [TBTT_W-1:0] tbtt2;
  // stage 3
  logic              v3;
  logic [MOD_W-1:0]  nextslot3;
  logic [IVAL_W-1:0] ival3;
  logic [TBTT_W-1:0] tbtt3;

  logic [20:0]       sum_us;
  logic [SPAN_W-1:0] span_next;
  logic [25:0]       span_round;
  logic [IVAL_W-1:0] tu;
  logic [IVAL_W-1:0] ival_next;
  logic [31:0]       ns_next;

  // only the low 26 bits of the slot time reach any result
  always_comb begin
    sum_us     = {1'b0, cfg.slot_length_us} + {5'b0, cfg.guard_time_us};
    span_next  = {4'b0, sum_us} * {21'b0, cfg.slot_count};
    span_round = {1'b0, span1} + 26'd1023;
    tu         = span_round[25:10];
    ival_next  = tu + {15'b0, tu[0]};
    ns_next    = rel2 + {7'b0, ival2, 9'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span1     <= span_next;
      rel1      <= rx_timestamp_us[31:0] - {16'b0, frame_airtime_us};
      tbtt1     <= next_tbtt_us[TBTT_W-1:0];
      ival2     <= ival_next;
      rel2      <= rel1;
      tbtt2     <= tbtt1;
      nextslot3 <= ns_next[MOD_W-1:0];
      ival3     <= ival2;
      tbtt3     <= tbtt2;
    end
  end

  assign front.valid    = v3;
  assign front.nextslot = nextslot3;
  assign front.ival     = ival3;
  assign front.tbtt     = tbtt3;

endmodule

>>> design/tsts_phase.sv
// Stages 4-5: TSF error against the programmed tbtt and forward pull.
module tsts_phase import tsts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  front_t front,
  output phase_t phase
);

  logic                   v4;
  logic [31:0]            err4;
  logic [PERIOD_BITS-1:0] slot4;
  logic [IVAL_W-1:0]      ival4;
  logic [31:0]            tbttu4;

  logic                   v5;
  logic [PERIOD_BITS-1:0] slot5;
  logic                   inc5;
  logic [PULL_W-1:0]      pull5;
  logic [IVAL_W-1:0]      ival5;
  logic [31:0]            tbttu5;

  logic [31:0]       err_next;
  logic [9:0]        neg_low;
  logic [PULL_W-1:0] pull_next;

  always_comb begin
    err_next = 32'(front.nextslot) - front.tbtt[31:0];
    neg_low  = 10'd0 - err4[9:0];
    if (err4[31]) begin
      pull_next = {1'b0, neg_low};
    end else if (err4 != 32'd0) begin
      pull_next = 11'd1024 - {1'b0, err4[9:0]};
    end else begin
      pull_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= front.valid;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err4   <= err_next;
      slot4  <= front.nextslot[MOD_W-1:TU_SHIFT];
      ival4  <= front.ival;
      tbttu4 <= front.tbtt[TBTT_W-1:TU_SHIFT];
      slot5  <= slot4;
      inc5   <= err4 != 32'd0;
      pull5  <= pull_next;
      ival5  <= ival4;
      tbttu5 <= tbttu4;
    end
  end

  assign phase.valid   = v5;
  assign phase.slot    = slot5;
  assign phase.inc     = inc5;
  assign phase.pull    = pull5;
  assign phase.ival    = ival5;
  assign phase.tbtt_tu = tbttu5;

endmodule

>>> design/tsts_timer.sv
// Stages 6-7: TU difference, timer write decision and output register.
module tsts_timer import tsts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cfg_t        cfg,
  input  phase_t      phase,
  output logic        out_valid,
  output logic        timer_write,
  output logic [16:0] new_tbtt_tu,
  output logic [15:0] interval_tu,
  output logic [31:0] new_dba_time,
  output logic [31:0] new_swba_time,
  output logic [16:0] new_atim_tu,
  output logic        tsf_pull,
  output logic [10:0] tsf_pull_us
);

  logic              v6;
  logic [SLOT_W-1:0] slot6;
  logic [31:0]       diff6;
  logic [IVAL_W-1:0] ival6;
  logic [PULL_W-1:0] pull6;

  logic [SLOT_W-1:0] slot_next;
  logic [31:0]       mag;
  logic              write;
  logic [31:0]       tbtt8;
  logic [31:0]       atim;

  always_comb begin
    slot_next = {1'b0, phase.slot} + {{(SLOT_W-1){1'b0}}, phase.inc};
    mag       = 32'd0 - diff6;
    // behind by less than one interval still counts as a rewrite
    write     = (diff6 != 32'd0) && (!diff6[31] || (mag < {16'b0, ival6}));
    tbtt8     = 32'(slot6) << 3;
    atim      = 32'(slot6) + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v6        <= phase.valid;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot6         <= slot_next;
      diff6         <= 32'(slot_next) - phase.tbtt_tu;
      ival6         <= phase.ival;
      pull6         <= phase.pull;
      timer_write   <= write;
      new_tbtt_tu   <= write ? 17'(slot6) : 17'd0;
      interval_tu   <= ival6;
      new_dba_time  <= write ? (tbtt8 - {16'b0, cfg.dba_prep_time}) : 32'd0;
      new_swba_time <= write ? (tbtt8 - {16'b0, cfg.swba_prep_time}) : 32'd0;
      new_atim_tu   <= write ? atim[16:0] : 17'd0;
      tsf_pull      <= pull6 != '0;
      tsf_pull_us   <= pull6;
    end
  end

endmodule

>>> design/tdma_slot_timer_sync_core.sv
// TDMA slot timer sync: top level, seven-stage pipeline.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    rx_timestamp_us, frame_airtime_us, next_tbtt_us
//  out      source     out_valid/out_ready  timer_write .. tsf_pull_us (one per request)
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
// Seven register stages (interval multiply, 32-bit adds and compares per stage);
// one request enters per cycle whenever the output is empty or out_ready is high.
// Synchronous reset empties the pipeline and loads config defaults.
// When a result sits at the output and out_ready is low, every stage holds.
module tdma_slot_timer_sync_core import tsts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           rx_timestamp_us,
  input  logic [15:0]           frame_airtime_us,
  input  logic [63:0]           next_tbtt_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  timer_write,
  output logic [16:0]           new_tbtt_tu,
  output logic [15:0]           interval_tu,
  output logic [31:0]           new_dba_time,
  output logic [31:0]           new_swba_time,
  output logic [16:0]           new_atim_tu,
  output logic                  tsf_pull,
  output logic [10:0]           tsf_pull_us
);

  cfg_t   cfg;
  front_t front;
  phase_t phase;
  logic   adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  tsts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsts_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (adv),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .rx_timestamp_us  (rx_timestamp_us),
    .frame_airtime_us (frame_airtime_us),
    .next_tbtt_us     (next_tbtt_us),
    .front            (front)
  );

  tsts_phase u_phase (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .front (front),
    .phase (phase)
  );

  tsts_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .en            (adv),
    .cfg           (cfg),
    .phase         (phase),
    .out_valid     (out_valid),
    .timer_write   (timer_write),
    .new_tbtt_tu   (new_tbtt_tu),
    .interval_tu   (interval_tu),
    .new_dba_time  (new_dba_time),
    .new_swba_time (new_swba_time),
    .new_atim_tu   (new_atim_tu),
    .tsf_pull      (tsf_pull),
    .tsf_pull_us   (tsf_pull_us)
  );

endmodule

>>> design/tsts_checker.sv
// Port-level checks for the slot timer sync core, bound to the top level.
module tsts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        timer_write,
  input logic [16:0] new_tbtt_tu,
  input logic [15:0] interval_tu,
  input logic [31:0] new_dba_time,
  input logic [16:0] new_atim_tu,
  input logic        tsf_pull,
  input logic [10:0] tsf_pull_us
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_pull: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tsf_pull == (tsf_pull_us != 11'd0)) && (tsf_pull_us <= 11'd1024))
    else $error("pull flag and amount disagree");

  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !timer_write |->
      (new_tbtt_tu == 17'd0) && (new_atim_tu == 17'd0) && (new_dba_time == 32'd0))
    else $error("timer values without timer write");

  a_atim: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_write |-> new_atim_tu == 17'(new_tbtt_tu + 17'd1))
    else $error("atim not one TU after tbtt");

  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !interval_tu[0])
    else $error("odd beacon interval");

endmodule

bind tdma_slot_timer_sync_core tsts_checker u_tsts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .timer_write  (timer_write),
  .new_tbtt_tu  (new_tbtt_tu),
  .interval_tu  (interval_tu),
  .new_dba_time (new_dba_time),
  .new_atim_tu  (new_atim_tu),
  .tsf_pull     (tsf_pull),
  .tsf_pull_us  (tsf_pull_us)
);

>>> tb/sv/tdma_slot_timer_sync_core_test.sv
// Self-checking testbench for the TDMA slot timer sync core.
module tdma_slot_timer_sync_core_test;
  import tsts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 185;

  typedef struct packed {
    logic        timer_write;
    logic [16:0] tbtt_tu;
    logic [15:0] ival;
    logic [31:0] dba;
    logic [31:0] swba;
    logic [16:0] atim;
    logic        pull;
    logic [10:0] pull_us;
  } slot_timing_t;

  typedef struct packed {
    logic [63:0]  rx;
    logic [15:0]  air;
    logic [63:0]  tbtt;
    logic         typed;
    slot_timing_t want;
  } beacon_row_t;

  // reset config: interval 20 TU, next slot at 10240 us
  localparam slot_timing_t FIRST_SLOT =
    '{1'b1, 17'd11, 16'd20, 32'd88, 32'd88, 17'd12, 1'b1, 11'd1024};
  localparam slot_timing_t IDLE_SLOT =
    '{1'b0, 17'd0, 16'd20, 32'd0, 32'd0, 17'd0, 1'b0, 11'd0};
  localparam slot_timing_t NONE = '0;

  localparam beacon_row_t BEACON_ROWS [0:14] = '{
    '{64'd0, 16'd0, 64'd0, 1'b1, FIRST_SLOT},
    // aligned: no error, no timer write
    '{64'd0, 16'd0, 64'd10240, 1'b1, IDLE_SLOT},
    // negative error that is a whole TU: no pull
    '{64'd0, 16'd0, 64'd11264, 1'b1, IDLE_SLOT},
    // most negative error
    '{64'd0, 16'd0, 64'h0000_0000_8000_2800, 1'b1, IDLE_SLOT},
    // most negative TU difference
    '{64'd0, 16'd0, 64'h0000_0200_0000_2800, 1'b1, IDLE_SLOT},
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NONE},
    '{64'd0, 16'hFFFF, 64'd0, 1'b0, NONE},
    '{64'h8000_0000_0000_0000, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NONE},
    '{64'd0, 16'd0, 64'd9940, 1'b0, NONE},
    '{64'd0, 16'd0, 64'd15460, 1'b0, NONE},
    // difference of minus one interval, then one inside it
    '{64'd0, 16'd0, 64'd31744, 1'b0, NONE},
    '{64'd0, 16'd0, 64'd30720, 1'b0, NONE},
    '{64'h0123_4567_89AB_CDEF, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NONE},
    '{64'd67098629, 16'd0, 64'd0, 1'b0, NONE},
    '{64'hFEDC_BA98_7654_3210, 16'hAAAA, 64'h5555_5555_5555_5555, 1'b0, NONE}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [63:0]           rx_timestamp_us = '0;
  logic [15:0]           frame_airtime_us = '0;
  logic [63:0]           next_tbtt_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  timer_write;
  logic [16:0]           new_tbtt_tu;
  logic [15:0]           interval_tu;
  logic [31:0]           new_dba_time;
  logic [31:0]           new_swba_time;
  logic [16:0]           new_atim_tu;
  logic                  tsf_pull;
  logic [10:0]           tsf_pull_us;

  cfg_t         cfg_now = '{SLOT_LENGTH_RST, GUARD_TIME_RST, SLOT_COUNT_RST,
                            DBA_PREP_RST, SWBA_PREP_RST};
  slot_timing_t pending_timing [$];
  logic         typed_on = 1'b0;
  slot_timing_t typed_want = '0;
  int unsigned  mismatches = 0;
  int unsigned  hold_kick = 0;
  slot_timing_t got_t, want_t;

  tdma_slot_timer_sync_core DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] beacon_ival(cfg_t c);
    logic [63:0] span, tu;
    span = (64'(c.slot_length_us) + 64'(c.guard_time_us)) * 64'(c.slot_count);
    tu = (span + 64'd1023) >> TU_SHIFT;
    if (tu[0]) tu = tu + 64'd1;
    return tu[31:0];
  endfunction

  function automatic slot_timing_t slot_timing(cfg_t c, logic [63:0] rx, logic [15:0] air,
                                               logic [63:0] tbtt);
    logic [31:0]  ival, slot, err, pull_amt, diff, mag;
    logic [63:0]  ns, nsmod;
    logic         wr;
    slot_timing_t r;
    ival = beacon_ival(c);
    ns = rx - 64'(air) + (64'(ival) << 9);
    slot = 32'((ns >> TU_SHIFT) & ((64'd1 << PERIOD_BITS) - 64'd1));
    nsmod = ns & ((64'd1 << MOD_W) - 64'd1);
    err = 32'(nsmod - tbtt);
    pull_amt = '0;
    if (err[31]) begin
      pull_amt = (32'd0 - err) % 32'd1024;
      slot = slot + 32'd1;
    end else if (err != 32'd0) begin
      pull_amt = 32'd1024 - (err % 32'd1024);
      slot = slot + 32'd1;
    end
    diff = slot - 32'(tbtt >> TU_SHIFT);
    mag = 32'd0 - diff;
    wr = (diff != 32'd0) && (!diff[31] || mag < ival);
    r.timer_write = wr;
    r.tbtt_tu = wr ? slot[16:0] : '0;
    r.ival = ival[15:0];
    r.dba = wr ? (slot << 3) - 32'(c.dba_prep_time) : '0;
    r.swba = wr ? (slot << 3) - 32'(c.swba_prep_time) : '0;
    r.atim = wr ? 17'(slot + 32'd1) : '0;
    r.pull = pull_amt != 32'd0;
    r.pull_us = pull_amt[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // one request; returns at the edge where it is taken
  task automatic offer(logic [63:0] rx, logic [15:0] air, logic [63:0] tbtt, logic typed,
                       slot_timing_t want);
    in_valid <= 1'b1;
    rx_timestamp_us <= rx;
    frame_airtime_us <= air;
    next_tbtt_us <= tbtt;
    typed_on <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_timing.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SLOT_LENGTH: cfg_now.slot_length_us = data[19:0];
      REG_GUARD_TIME:  cfg_now.guard_time_us = data[15:0];
      REG_SLOT_COUNT:  cfg_now.slot_count = data[3:0];
      REG_DBA_PREP:    cfg_now.dba_prep_time = data[15:0];
      REG_SWBA_PREP:   cfg_now.swba_prep_time = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_t = '{timer_write, new_tbtt_tu, interval_tu, new_dba_time, new_swba_time,
                  new_atim_tu, tsf_pull, tsf_pull_us};
        if (pending_timing.size() == 0) begin
          report_mismatch($sformatf("result %0h with no request pending", got_t));
        end else begin
          want_t = pending_timing.pop_front();
          check_field("timer_write", 64'(got_t.timer_write), 64'(want_t.timer_write));
          check_field("new_tbtt_tu", 64'(got_t.tbtt_tu), 64'(want_t.tbtt_tu));
          check_field("interval_tu", 64'(got_t.ival), 64'(want_t.ival));
          check_field("new_dba_time", 64'(got_t.dba), 64'(want_t.dba));
          check_field("new_swba_time", 64'(got_t.swba), 64'(want_t.swba));
          check_field("new_atim_tu", 64'(got_t.atim), 64'(want_t.atim));
          check_field("tsf_pull", 64'(got_t.pull), 64'(want_t.pull));
          check_field("tsf_pull_us", 64'(got_t.pull_us), 64'(want_t.pull_us));
        end
      end
      if (in_valid && in_ready)
        pending_timing.push_back(typed_on ? typed_want
          : slot_timing(cfg_now, rx_timestamp_us, frame_airtime_us, next_tbtt_us));
    end
  end

  // receiver: pattern modes, plus a long hold-off when kicked
  initial begin : sink_side
    int unsigned mode, left, hold, seen, tick;
    mode = 0;
    left = 0;
    hold = 0;
    seen = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_kick != seen) begin
        seen = hold_kick;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 256);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tdma_slot_timer_sync_core verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] rx, tbtt, ns, nsmod;
    logic [15:0] air;
    longint      off;
    int unsigned iv, kind, burst;
    cfg_t        s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beacons on reset config
    foreach (BEACON_ROWS[i]) begin
      offer(BEACON_ROWS[i].rx, BEACON_ROWS[i].air, BEACON_ROWS[i].tbtt,
            BEACON_ROWS[i].typed, BEACON_ROWS[i].want);
      if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 3));
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = '{SLOT_LENGTH_RST, GUARD_TIME_RST, SLOT_COUNT_RST, DBA_PREP_RST, SWBA_PREP_RST};
        1: s = '{20'hFFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF};
        2: s = '0;
        3: s = '{20'd1, 16'd0, 4'd1, 16'hFFFF, 16'd1};
        4: s = '{20'hFFFFF, 16'd0, 4'd8, 16'd0, 16'hFFFF};
        default: begin
          s.slot_length_us = $urandom_range(0, 1) ? 20'($urandom_range(500, 40000))
                                                  : 20'($urandom_range(0, 20'hFFFFF));
          s.guard_time_us = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                                 : 16'($urandom);
          s.slot_count = 4'($urandom_range(0, 15));
          s.dba_prep_time = 16'($urandom);
          s.swba_prep_time = 16'($urandom);
        end
      endcase
      // upper data bits are junk for the narrow registers
      cfg_put(REG_SLOT_LENGTH, s.slot_length_us);
      cfg_put(REG_GUARD_TIME, {4'($urandom), s.guard_time_us});
      cfg_put(REG_SLOT_COUNT, {16'($urandom), s.slot_count});
      cfg_put(REG_DBA_PREP, {4'($urandom), s.dba_prep_time});
      cfg_put(REG_SWBA_PREP, {4'($urandom), s.swba_prep_time});
      cfg_put(CFG_IDX_W'(REG_SWBA_PREP) + CFG_IDX_W'($urandom_range(1, 3)),
              CFG_DATA_W'($urandom));
      cfg_write <= 1'b0;
      @(posedge clk);
      hold_kick <= hold_kick + 1;

      iv = beacon_ival(cfg_now);
      burst = $urandom_range(1, 40);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rx = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) rx = rx >> $urandom_range(0, 63);
        air = 16'($urandom);
        ns = rx - 64'(air) + (64'(iv) << 9);
        nsmod = ns & ((64'd1 << MOD_W) - 64'd1);
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          // next TBTT close to where our slot lands
          case ($urandom_range(0, 4))
            0: off = longint'($urandom_range(0, 4000)) - 2000;
            1: off = (longint'($urandom_range(0, 2 * iv + 4)) - longint'(iv) - 2) * 1024
                     + longint'($urandom_range(0, 1023));
            2: off = 0;
            3: off = (longint'($urandom_range(0, 6)) - 3) * 1024;
            default: off = longint'(int'($urandom));
          endcase
          tbtt = nsmod + 64'(off);
        end else if (kind < 80) begin
          case ($urandom_range(0, 2))
            0: tbtt = nsmod + (64'd1 << 31);
            1: tbtt = nsmod + (64'd1 << (TU_SHIFT + 31));
            default: tbtt = nsmod - (64'd1 << 31);
          endcase
        end else begin
          tbtt = {$urandom, $urandom};
        end
        offer(rx, air, tbtt, 1'b0, NONE);
        burst--;
        if (burst == 0) begin
          if ($urandom_range(0, 4) != 0) idle($urandom_range(1, 9));
          burst = $urandom_range(1, 40);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("tdma_slot_timer_sync_core verification clean");
    end else begin
      $display("tdma_slot_timer_sync_core verification failed");
    end
    $finish;
  end

endmodule
